[hdl/atnp_pkg.sv]
// Shared types, constants and keyword table for the AT notification line parser.
// No dependencies; imported by every module in hdl/.
package atnp_pkg;

  localparam int LINE_BYTES   = 128;
  localparam int LEN_W        = $clog2(LINE_BYTES);
  localparam int KEYWORDS     = 6;
  localparam int KW_MAX       = 13;
  localparam int VOL_OFFSET   = 5;
  localparam int STATE_OFFSET = 7;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // keyword index = priority order; text right-justified, first char at byte len-1
  localparam logic [KW_MAX*8-1:0] KW_TEXT [KEYWORDS] = '{
    "+CONNECTED:", "+DISCONNECTED", "+PLAY", "+PAUSE", "+VOL:", "+STATE:"
  };
  localparam logic [3:0] KW_LEN [KEYWORDS] = '{
    4'd11, 4'd13, 4'd5, 4'd6, 4'd5, 4'd7
  };

  localparam int KW_CONNECTED    = 0;
  localparam int KW_DISCONNECTED = 1;
  localparam int KW_PLAY         = 2;
  localparam int KW_PAUSE        = 3;
  localparam int KW_VOL          = 4;
  localparam int KW_STATE        = 5;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CONNECTED    = 3'd1,
    EV_DISCONNECTED = 3'd2,
    EV_PLAY         = 3'd3,
    EV_PAUSE        = 3'd4,
    EV_VOLUME       = 3'd5,
    EV_STATE        = 3'd6
  } event_kind_t;

  typedef enum logic [1:0] {
    LS_DISCONNECTED = 2'd0,
    LS_CONNECTING   = 2'd1,
    LS_CONNECTED    = 2'd2,
    LS_PLAYING      = 2'd3
  } link_state_t;

  typedef enum logic [1:0] {
    PH_SKIP  = 2'd0,
    PH_DIGIT = 2'd1,
    PH_DONE  = 2'd2
  } parse_phase_t;

  localparam logic [7:0] VOLUME_RESET = 8'd50;
  localparam logic [7:0] STATE_SAT    = 8'd4;

  // running number value seen so far in a line
  typedef struct packed {
    logic       negative;
    logic       nonzero;
    logic [7:0] value;
  } num_res_t;

  function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
    logic [KW_MAX*8-1:0] s;
    logic [3:0]          pos;
    s   = KW_TEXT[k];
    pos = KW_LEN[k] - 4'd1 - p;
    return s[8*pos +: 8];
  endfunction

endpackage

[hdl/at_notification_line_parser.sv]
// Top level: input register, line tracking, keyword/number units, result register.
// Depends on atnp_pkg, atnp_kw_match, atnp_num_parse.
// Path from accepted byte to result: input register, then result register.
// Throughput: one byte per cycle; the result register stalls the input only when full
// and not taken. One result per non-empty line, on the byte that ends it.
// Reset (rst, synchronous): empty line, link disconnected, volume 50, both sides empty.
module at_notification_line_parser import atnp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] link_state, [9:2] volume,
                                 // [12:10] event_kind, [13] notify, [15:14] zero
);

  logic             in_vld;
  logic [7:0]       in_byte;
  logic             adv;
  logic             is_term;
  logic             keep;
  logic             line_done;
  logic [LEN_W-1:0] line_length;
  logic [KEYWORDS-1:0] seen;
  num_res_t         vol_res;
  num_res_t         st_res;
  link_state_t      link_state_reg, link_next;
  logic [7:0]       volume_reg, volume_next;
  event_kind_t      kind;

  assign adv      = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  assign is_term   = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign keep      = adv && !is_term && (line_length < LEN_W'(LINE_BYTES - 1));
  assign line_done = adv && is_term && (line_length != '0);

  always_ff @(posedge clk) begin
    if (rst || line_done) begin
      line_length <= '0;
    end else if (keep) begin
      line_length <= line_length + 1'b1;
    end
  end

  atnp_kw_match u_kw (
    .clk  (clk),
    .rst  (rst),
    .feed (keep),
    .clr  (line_done),
    .c    (in_byte),
    .seen (seen)
  );

  atnp_num_parse u_vol (
    .clk   (clk),
    .rst   (rst),
    .feed  (keep && line_length >= LEN_W'(VOL_OFFSET)),
    .clr   (line_done),
    .wrap8 (1'b1),
    .c     (in_byte),
    .res   (vol_res)
  );

  atnp_num_parse u_state (
    .clk   (clk),
    .rst   (rst),
    .feed  (keep && line_length >= LEN_W'(STATE_OFFSET)),
    .clr   (line_done),
    .wrap8 (1'b0),
    .c     (in_byte),
    .res   (st_res)
  );

  // first keyword seen in priority order decides the event
  always_comb begin
    link_next   = link_state_reg;
    volume_next = volume_reg;
    kind        = EV_NONE;
    if (seen[KW_CONNECTED]) begin
      link_next = LS_CONNECTED;
      kind      = EV_CONNECTED;
    end else if (seen[KW_DISCONNECTED]) begin
      link_next = LS_DISCONNECTED;
      kind      = EV_DISCONNECTED;
    end else if (seen[KW_PLAY]) begin
      link_next = LS_PLAYING;
      kind      = EV_PLAY;
    end else if (seen[KW_PAUSE]) begin
      if (link_state_reg == LS_PLAYING) link_next = LS_CONNECTED;
      kind = EV_PAUSE;
    end else if (seen[KW_VOL]) begin
      kind = EV_VOLUME;
      if (!vol_res.negative && vol_res.nonzero) volume_next = vol_res.value;
    end else if (seen[KW_STATE]) begin
      kind = EV_STATE;
      // -0 still counts as zero; saturated value 4 means out of range
      if (!(st_res.negative && st_res.nonzero) && st_res.value <= 8'd3) begin
        link_next = link_state_t'(st_res.value[1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_state_reg <= LS_DISCONNECTED;
      volume_reg     <= VOLUME_RESET;
    end else if (line_done) begin
      link_state_reg <= link_next;
      volume_reg     <= volume_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= line_done;
    end
  end

  always_ff @(posedge clk) begin
    if (line_done) begin
      m_tdata <= {2'b00,
                  (kind == EV_CONNECTED || kind == EV_DISCONNECTED ||
                   kind == EV_PLAY || kind == EV_PAUSE),
                  kind, volume_next, link_next};
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_BYTES - 1))
    else $error("line length past kept limit");

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    line_done |=> (line_length == '0) && (seen == '0))
    else $error("line state not cleared after result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    line_done |=> m_tvalid)
    else $error("completed line gave no result");

  a_pause_not_playing: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12:10] == EV_PAUSE) |-> (m_tdata[1:0] != LS_PLAYING))
    else $error("pause left link playing");

  a_notify_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[13] == (m_tdata[12:10] != EV_NONE &&
                                  m_tdata[12:10] <= EV_PAUSE)))
    else $error("notify does not match event kind");

endmodule

[hdl/atnp_kw_match.sv]
// Six streaming keyword matchers with per-line hit flags.
// Depends on atnp_pkg.
module atnp_kw_match import atnp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                feed,    // kept byte of the current line
  input  logic                clr,     // line finished
  input  logic [7:0]          c,
  output logic [KEYWORDS-1:0] seen
);

  logic [3:0]          prog      [KEYWORDS];
  logic [3:0]          prog_next [KEYWORDS];
  logic [KEYWORDS-1:0] seen_next;

  always_comb begin
    logic [3:0] p;
    logic       hit;
    seen_next = seen;
    for (int k = 0; k < KEYWORDS; k++) begin
      p   = prog[k];
      hit = (p < KW_LEN[k]) && (kw_char(k, p) == c);
      if (hit) begin
        p = p + 4'd1;
      end else begin
        p = (c == CH_PLUS) ? 4'd1 : 4'd0;
      end
      if (p >= KW_LEN[k]) begin
        seen_next[k] = 1'b1;
        p = 4'd0;
      end
      prog_next[k] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      seen <= '0;
      for (int k = 0; k < KEYWORDS; k++) prog[k] <= '0;
    end else if (feed) begin
      seen <= seen_next;
      for (int k = 0; k < KEYWORDS; k++) prog[k] <= prog_next[k];
    end
  end

endmodule

[hdl/atnp_num_parse.sv]
// atoi-style decimal reader: blanks, optional sign, digits.
// wrap8 selects modulo-256 value, else saturation at 4. Depends on atnp_pkg.
module atnp_num_parse import atnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       feed,
  input  logic       clr,
  input  logic       wrap8,
  input  logic [7:0] c,
  output num_res_t   res
);

  parse_phase_t phase, phase_next;
  num_res_t     res_next;

  always_comb begin
    logic        digit;
    logic        blank;
    logic [11:0] acc;
    logic        in_digits;
    digit      = (c >= CH_ZERO) && (c <= CH_NINE);
    blank      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    acc        = {1'b0, res.value, 3'b0} + {3'b0, res.value, 1'b0} +
                 {4'b0, c - CH_ZERO};
    phase_next = phase;
    res_next   = res;
    in_digits  = 1'b0;
    case (phase)
      PH_SKIP: begin
        if (!blank) begin
          phase_next = PH_DIGIT;
          if (c == CH_PLUS || c == CH_MINUS) begin
            res_next.negative = (c == CH_MINUS);
          end else begin
            in_digits = 1'b1;
          end
        end
      end
      PH_DIGIT: in_digits = 1'b1;
      PH_DONE:  ;
      default:  ;
    endcase
    if (in_digits) begin
      if (!digit) begin
        phase_next = PH_DONE;
      end else begin
        if (c != CH_ZERO) res_next.nonzero = 1'b1;
        if (wrap8) begin
          res_next.value = acc[7:0];
        end else begin
          res_next.value = (acc > {4'b0, STATE_SAT}) ? STATE_SAT : acc[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      phase <= PH_SKIP;
      res   <= '0;
    end else if (feed) begin
      phase <= phase_next;
      res   <= res_next;
    end
  end

endmodule
